FILE: rtl/astar_grid_path_search_assert.svh
// ----------------------------------------------------------------------------
// astar_grid_path_search assertion macros
// Clocked property wrappers used by the path search datapath.
// ----------------------------------------------------------------------------
`ifndef ASTAR_GRID_PATH_SEARCH_ASSERT_SVH
`define ASTAR_GRID_PATH_SEARCH_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define AGP_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define AGP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/agp_pkg.sv
// ----------------------------------------------------------------------------
// agp_pkg
// Types and fixed constants of the grid path search block.
// ----------------------------------------------------------------------------
package agp_pkg;

   localparam int PATH_COST_BITS = 22;
   localparam logic [PATH_COST_BITS-1:0] COST_MAX = 22'h3FFFFF;

   localparam logic [1:0] KIND_LOAD   = 2'd0;
   localparam logic [1:0] KIND_EDGE   = 2'd1;
   localparam logic [1:0] KIND_SEARCH = 2'd2;

   localparam logic CSR_START = 1'b0;
   localparam logic CSR_GOAL  = 1'b1;

   typedef struct packed {
      logic [1:0]  kind;
      logic [5:0]  node_id;
      logic [7:0]  x_coord;
      logic [7:0]  y_coord;
      logic [15:0] entry_cost;
      logic [5:0]  neighbor_id;
   } req_word_type;

   typedef struct packed {
      logic [5:0]  path_node;
      logic [21:0] path_cost;
      logic        found;
      logic        last;
   } rsp_word_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_EDGE, ST_GOAL, ST_SCAN, ST_DECIDE, ST_DEG, ST_ADJ,
      ST_NB, ST_RELAX, ST_WALK, ST_PRED, ST_OUT, ST_NF
   } state_type;

   typedef struct packed {
      logic load_node;
      logic edge_rd;
      logic edge_wr;
      logic search_init;
      logic goal_latch;
      logic scan;
      logic decide;
      logic deg_latch;
      logic adj_issue;
      logic nb_check;
      logic relax;
      logic walk;
      logic pred_take;
      logic out_step;
      logic emit_nf;
   } cmd_type;

   typedef struct packed {
      logic ends_ok;
      logic scan_last;
      logic any;
      logic pick_goal;
      logic k_done;
      logic nb_skip;
      logic walk_done;
      logic out_last;
   } status_type;

endpackage

FILE: rtl/agp_ctrl.sv
// ----------------------------------------------------------------------------
// agp_ctrl
// Sequencer of the path search: decodes words and steps the datapath.
// ----------------------------------------------------------------------------
module agp_ctrl
   import agp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  logic [1:0] kind,
   input  status_type status,
   output cmd_type    cmd,
   output logic       busy
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               unique case (kind)
                  KIND_LOAD: begin
                     cmd.load_node = 1'b1;
                  end
                  KIND_EDGE: begin
                     cmd.edge_rd = 1'b1;
                     state_in    = ST_EDGE;
                  end
                  KIND_SEARCH: begin
                     if (status.ends_ok) begin
                        cmd.search_init = 1'b1;
                        state_in        = ST_GOAL;
                     end else begin
                        state_in = ST_NF;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_EDGE: begin
            cmd.edge_wr = 1'b1;
            state_in    = ST_IDLE;
         end
         ST_GOAL: begin
            cmd.goal_latch = 1'b1;
            state_in       = ST_SCAN;
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (status.scan_last) state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            cmd.decide = 1'b1;
            if (!status.any) state_in = ST_NF;
            else if (status.pick_goal) state_in = ST_WALK;
            else state_in = ST_DEG;
         end
         ST_DEG: begin
            cmd.deg_latch = 1'b1;
            state_in      = ST_ADJ;
         end
         ST_ADJ: begin
            cmd.adj_issue = 1'b1;
            state_in      = status.k_done ? ST_SCAN : ST_NB;
         end
         ST_NB: begin
            cmd.nb_check = 1'b1;
            state_in     = status.nb_skip ? ST_ADJ : ST_RELAX;
         end
         ST_RELAX: begin
            cmd.relax = 1'b1;
            state_in  = ST_ADJ;
         end
         ST_WALK: begin
            cmd.walk = 1'b1;
            state_in = status.walk_done ? ST_OUT : ST_PRED;
         end
         ST_PRED: begin
            cmd.pred_take = 1'b1;
            state_in      = ST_WALK;
         end
         ST_OUT: begin
            cmd.out_step = 1'b1;
            if (status.out_last) state_in = ST_IDLE;
         end
         ST_NF: begin
            cmd.emit_nf = 1'b1;
            state_in    = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

FILE: rtl/agp_dpath.sv
// ----------------------------------------------------------------------------
// agp_dpath
// Node, edge and search stores with the scan, relax and path walk logic.
// ----------------------------------------------------------------------------
`include "astar_grid_path_search_assert.svh"

module agp_dpath
   import agp_pkg::*;
#(
   parameter int NODE_COUNT = 64,
   parameter int MAX_DEGREE = 4,
   parameter int COORD_BITS = 8,
   parameter int COST_BITS  = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  req_word_type req_word,
   input  logic         csr_we,
   input  logic         csr_index,
   input  logic [5:0]   csr_wdata,
   input  cmd_type      cmd,
   output status_type   status,
   output logic         rsp_valid,
   output rsp_word_type rsp_word
);

   localparam int ID_W  = $clog2(NODE_COUNT);
   localparam int CNT_W = $clog2(NODE_COUNT + 1);
   localparam int ADJ_W = $clog2(NODE_COUNT * MAX_DEGREE);
   localparam int DEG_W = $clog2(MAX_DEGREE + 1);
   localparam int F_W   = PATH_COST_BITS + 1;
   localparam int SUM_W = 34;

   // stores
   logic [COORD_BITS-1:0]     px_mem   [NODE_COUNT];
   logic [COORD_BITS-1:0]     py_mem   [NODE_COUNT];
   logic [COST_BITS-1:0]      cost_mem [NODE_COUNT];
   logic [ID_W-1:0]           adj_mem  [NODE_COUNT*MAX_DEGREE];
   logic [DEG_W-1:0]          deg_mem  [NODE_COUNT];
   logic [PATH_COST_BITS-1:0] best_mem [NODE_COUNT];
   logic [ID_W-1:0]           pred_mem [NODE_COUNT];
   logic [ID_W-1:0]           pb_mem   [NODE_COUNT];

   logic [NODE_COUNT-1:0] node_set_ff, deg_set_ff, reached_ff, open_ff, closed_ff;

   logic [COORD_BITS-1:0]     px_rd_ff, py_rd_ff;
   logic [COST_BITS-1:0]      cost_rd_ff;
   logic [ID_W-1:0]           adj_rd_ff, pred_rd_ff, pb_rd_ff;
   logic [DEG_W-1:0]          deg_rd_ff;
   logic [PATH_COST_BITS-1:0] best_rd_ff;
   logic                      node_vld_ff, deg_vld_ff, reached_rd_ff;

   logic [5:0] start_ff, goal_ff;
   logic [ID_W-1:0] s_id, t_id;

   logic [ID_W-1:0] edge_id_ff, edge_nb_ff;
   logic            edge_ok_ff;
   logic [COORD_BITS-1:0] gx_ff, gy_ff;
   logic [CNT_W-1:0] cnt_ff, len_ff, j_ff;
   logic [ID_W-1:0]  sidx_ff, pick_ff, nb_ff, cur_ff;
   logic             any_ff;
   logic [F_W-1:0]   bestf_ff;
   logic [PATH_COST_BITS-1:0] pick_g_ff;
   logic [DEG_W-1:0] deg_ff, k_ff;

   logic rsp_valid_ff;
   rsp_word_type rsp_ff;

   // decode helpers
   logic            id_ok, nb_ok;
   logic [ID_W-1:0] req_id, req_nb;
   logic [15:0]     x_ext, y_ext;
   logic [31:0]     c_ext;
   logic [NODE_COUNT-1:0] start_onehot;

   assign id_ok  = {1'b0, req_word.node_id} < 7'(NODE_COUNT);
   assign nb_ok  = {1'b0, req_word.neighbor_id} < 7'(NODE_COUNT);
   assign req_id = req_word.node_id[ID_W-1:0];
   assign req_nb = req_word.neighbor_id[ID_W-1:0];
   assign x_ext  = 16'(req_word.x_coord);
   assign y_ext  = 16'(req_word.y_coord);
   assign c_ext  = 32'(req_word.entry_cost);
   assign s_id   = start_ff[ID_W-1:0];
   assign t_id   = goal_ff[ID_W-1:0];
   assign start_onehot = {{(NODE_COUNT-1){1'b0}}, 1'b1} << s_id;

   // read addresses
   logic [ID_W-1:0]  node_ra, deg_ra, best_ra, pb_ra;
   logic [ADJ_W-1:0] adj_ra, adj_wa;
   logic [CNT_W-1:0] out_idx;

   always_comb begin
      node_ra = t_id;
      if (cmd.scan) node_ra = cnt_ff[ID_W-1:0];
      else if (cmd.nb_check) node_ra = adj_rd_ff;
   end
   assign best_ra = node_ra;
   assign deg_ra  = cmd.decide ? pick_ff : req_id;
   assign adj_ra  = ADJ_W'(int'(pick_ff) * MAX_DEGREE + int'(k_ff));
   assign out_idx = len_ff - CNT_W'(1) - j_ff;
   assign pb_ra   = out_idx[ID_W-1:0];

   // evaluation
   logic [COORD_BITS-1:0] xv, yv, dx, dy;
   logic [PATH_COST_BITS-1:0] gv, old_g, ng;
   logic [F_W-1:0]   f_val;
   logic [COST_BITS-1:0] cost_v;
   logic [SUM_W-1:0] sum;
   logic [DEG_W-1:0] deg_v;
   logic scan_take, relax_win, edge_fits;

   always_comb begin
      xv     = node_vld_ff ? px_rd_ff : '0;
      yv     = node_vld_ff ? py_rd_ff : '0;
      dx     = (xv > gx_ff) ? xv - gx_ff : gx_ff - xv;
      dy     = (yv > gy_ff) ? yv - gy_ff : gy_ff - yv;
      gv     = reached_rd_ff ? best_rd_ff : COST_MAX;
      f_val  = F_W'(gv) + F_W'(dx) + F_W'(dy);
      scan_take = cmd.scan && (cnt_ff != '0) && open_ff[sidx_ff]
                  && (!any_ff || f_val < bestf_ff);
      cost_v = node_vld_ff ? cost_rd_ff : '0;
      sum    = SUM_W'(pick_g_ff) + SUM_W'(cost_v);
      ng     = (sum > SUM_W'(COST_MAX)) ? COST_MAX : sum[PATH_COST_BITS-1:0];
      old_g  = gv;
      relax_win = ng < old_g;
      deg_v  = deg_vld_ff ? deg_rd_ff : '0;
      edge_fits = edge_ok_ff && (deg_v < DEG_W'(MAX_DEGREE));
   end

   assign adj_wa = ADJ_W'(int'(edge_id_ff) * MAX_DEGREE + int'(deg_v));

   // memories
   always_ff @(posedge clock) begin
      if (cmd.load_node && id_ok) begin
         px_mem[req_id]   <= x_ext[COORD_BITS-1:0];
         py_mem[req_id]   <= y_ext[COORD_BITS-1:0];
         cost_mem[req_id] <= c_ext[COST_BITS-1:0];
      end
      px_rd_ff   <= px_mem[node_ra];
      py_rd_ff   <= py_mem[node_ra];
      cost_rd_ff <= cost_mem[node_ra];

      if (cmd.edge_wr && edge_fits) begin
         adj_mem[adj_wa]     <= edge_nb_ff;
         deg_mem[edge_id_ff] <= deg_v + DEG_W'(1);
      end
      adj_rd_ff <= adj_mem[adj_ra];
      deg_rd_ff <= deg_mem[deg_ra];

      if (cmd.search_init) best_mem[s_id] <= '0;
      else if (cmd.relax && relax_win) best_mem[nb_ff] <= ng;
      best_rd_ff <= best_mem[best_ra];

      if (cmd.relax && relax_win) pred_mem[nb_ff] <= pick_ff;
      pred_rd_ff <= pred_mem[cur_ff];

      if (cmd.walk) pb_mem[len_ff[ID_W-1:0]] <= cur_ff;
      pb_rd_ff <= pb_mem[pb_ra];
   end

   // valid bits and search marks
   always_ff @(posedge clock) begin
      if (reset) begin
         node_set_ff <= '0;
         deg_set_ff  <= '0;
         reached_ff  <= '0;
         open_ff     <= '0;
         closed_ff   <= '0;
         start_ff    <= '0;
         goal_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            if (csr_index == CSR_START) start_ff <= csr_wdata;
            else goal_ff <= csr_wdata;
         end
         if (cmd.load_node && id_ok) node_set_ff[req_id] <= 1'b1;
         if (cmd.edge_wr && edge_fits) deg_set_ff[edge_id_ff] <= 1'b1;
         if (cmd.search_init) begin
            // open the start node alone
            reached_ff <= start_onehot;
            open_ff    <= start_onehot;
            closed_ff  <= '0;
         end
         if (cmd.decide && any_ff && pick_ff != t_id) begin
            open_ff[pick_ff]   <= 1'b0;
            closed_ff[pick_ff] <= 1'b1;
         end
         if (cmd.relax && relax_win) begin
            reached_ff[nb_ff] <= 1'b1;
            open_ff[nb_ff]    <= 1'b1;
         end
         rsp_valid_ff <= cmd.emit_nf || (cmd.out_step && j_ff != '0);
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      node_vld_ff   <= node_set_ff[node_ra];
      reached_rd_ff <= reached_ff[best_ra];
      deg_vld_ff    <= deg_set_ff[deg_ra];
      if (cmd.edge_rd) begin
         edge_id_ff <= req_id;
         edge_nb_ff <= req_nb;
         edge_ok_ff <= id_ok && nb_ok;
      end
      if (cmd.goal_latch) begin
         gx_ff <= xv;
         gy_ff <= yv;
      end
      if (cmd.goal_latch || (cmd.adj_issue && status.k_done)) begin
         cnt_ff <= '0;
         any_ff <= 1'b0;
      end else if (cmd.scan) begin
         cnt_ff  <= cnt_ff + CNT_W'(1);
         sidx_ff <= cnt_ff[ID_W-1:0];
      end
      if (scan_take) begin
         any_ff    <= 1'b1;
         bestf_ff  <= f_val;
         pick_ff   <= sidx_ff;
         pick_g_ff <= gv;
      end
      if (cmd.decide) begin
         k_ff   <= '0;
         cur_ff <= t_id;
         len_ff <= '0;
      end
      if (cmd.deg_latch) deg_ff <= deg_v;
      if (cmd.nb_check) nb_ff <= adj_rd_ff;
      if ((cmd.nb_check && status.nb_skip) || cmd.relax) k_ff <= k_ff + DEG_W'(1);
      if (cmd.walk) begin
         len_ff <= len_ff + CNT_W'(1);
         j_ff   <= '0;
      end
      if (cmd.pred_take) cur_ff <= pred_rd_ff;
      if (cmd.out_step) j_ff <= j_ff + CNT_W'(1);
      if (cmd.emit_nf) begin
         rsp_ff <= '{path_node: 6'd0, path_cost: 22'd0, found: 1'b0, last: 1'b1};
      end else begin
         rsp_ff.path_node <= 6'(pb_rd_ff);
         rsp_ff.path_cost <= pick_g_ff;
         rsp_ff.found     <= 1'b1;
         rsp_ff.last      <= (j_ff == len_ff);
      end
   end

   assign status.ends_ok   = ({1'b0, start_ff} < 7'(NODE_COUNT))
                             && ({1'b0, goal_ff} < 7'(NODE_COUNT));
   assign status.scan_last = (cnt_ff == CNT_W'(NODE_COUNT));
   assign status.any       = any_ff;
   assign status.pick_goal = (pick_ff == t_id);
   assign status.k_done    = (k_ff >= deg_ff);
   assign status.nb_skip   = closed_ff[adj_rd_ff];
   assign status.walk_done = (cur_ff == s_id) || (len_ff == CNT_W'(NODE_COUNT - 1));
   assign status.out_last  = (j_ff == len_ff);

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   `AGP_ASSERT_NEXT(a_nf_word, cmd.emit_nf, rsp_valid_ff && !rsp_ff.found && rsp_ff.last,
      "not-found run must give one final word")
   `AGP_ASSERT_NEXT(a_init_open, cmd.search_init, $onehot(open_ff),
      "search must open the start node alone")
   `AGP_ASSERT_NEXT(a_path_burst, rsp_valid_ff && rsp_ff.found && !rsp_ff.last, rsp_valid_ff,
      "path words must come back to back")
   `AGP_ASSERT_SAME(a_out_len, cmd.out_step, len_ff != '0,
      "path output needs a nonempty path")

endmodule

FILE: rtl/astar_grid_path_search.sv
// ----------------------------------------------------------------------------
// astar_grid_path_search
// A* path search over a loaded grid graph, Manhattan distance ordering.
// ----------------------------------------------------------------------------
//  channel  ports                         handshake
//  request  start, busy, req_word         taken when start && !busy
//  result   rsp_valid, rsp_word           one-cycle strobe, no stall
//  config   csr_we, csr_index, csr_wdata  written when csr_we
//
//  Load writes a node record. Edge: degree read, then write. Search: setup and
//  goal latch, then open scans each ending in a decision, expansion of the
//  picked node (list read and closed check per neighbor, relax if not closed),
//  the walk back to the start and path word output; not found gives one word.
//  Reset is synchronous; valid bits clear the node and degree stores at once.
//  The receiver cannot stall; busy holds off requests during an edge write or a search.
// ----------------------------------------------------------------------------
module astar_grid_path_search
   import agp_pkg::*;
#(
   parameter int NODE_COUNT = 64,
   parameter int MAX_DEGREE = 4,
   parameter int COORD_BITS = 8,
   parameter int COST_BITS  = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  req_word_type req_word,
   output logic         rsp_valid,
   output rsp_word_type rsp_word,
   input  logic         csr_we,
   input  logic         csr_index,
   input  logic [5:0]   csr_wdata
);

   cmd_type    cmd;
   status_type status;

   // sequencer: decode the word kind and step the search phases
   agp_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .kind   (req_word.kind),
      .status (status),
      .cmd    (cmd),
      .busy   (busy)
   );

   // stores, open scan, relax and path walk
   agp_dpath #(
      .NODE_COUNT (NODE_COUNT),
      .MAX_DEGREE (MAX_DEGREE),
      .COORD_BITS (COORD_BITS),
      .COST_BITS  (COST_BITS)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_word  (req_word),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word)
   );

endmodule

FILE: bench/tb_astar_grid_path_search.sv
// ----------------------------------------------------------------------------
// tb_astar_grid_path_search
// Loads node records and edge lists into the A* path search block and runs
// searches between changing endpoints. A software copy of the graph predicts
// every path word, and each strobed result is checked field by field.
// ----------------------------------------------------------------------------
module tb_astar_grid_path_search;
   import agp_pkg::*;

   localparam int NODES      = 64;
   localparam int DEGREE_MAX = 4;
   localparam int IDLE_LIMIT = 60000;
   localparam int SETTLE     = 12;
   localparam int REQ_BITS   = $bits(req_word_type);

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         start = 1'b0;
   logic         busy;
   req_word_type req_word = '0;
   logic         rsp_valid;
   rsp_word_type rsp_word;
   logic         csr_we = 1'b0;
   logic         csr_index = CSR_START;
   logic [5:0]   csr_wdata = '0;

   // Graph copy held by the bench.
   logic [7:0]   node_x [NODES];
   logic [7:0]   node_y [NODES];
   logic [15:0]  node_cost [NODES];
   logic [5:0]   edge_list [NODES][DEGREE_MAX];
   int           edge_count [NODES];
   logic [5:0]   search_from = '0;
   logic [5:0]   search_to = '0;

   rsp_word_type path_words_due [$];
   int           fail_count = 0;
   int           words_sent = 0;
   int           words_seen = 0;
   int           searches_run = 0;
   int           misses_seen = 0;
   int           idle_cycles = 0;

   astar_grid_path_search DUT (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   // Append one predicted word at the tail of the due list.
   function automatic void expect_word(rsp_word_type w);
      path_words_due.insert(path_words_due.size(), w);
   endfunction

   // Run A* on the bench's graph copy and queue the path words it yields.
   function automatic void plan_path();
      logic [21:0] g [NODES];
      logic [5:0]  via [NODES];
      bit          open_set [NODES];
      bit          done_set [NODES];
      logic [5:0]  route [$];
      longint      f, best_f, ng;
      bit          any;
      int          pick, nb, cur;
      rsp_word_type w;
      for (int i = 0; i < NODES; i++) begin
         g[i] = COST_MAX;
         open_set[i] = 0;
         done_set[i] = 0;
         via[i] = '0;
      end
      g[search_from] = '0;
      open_set[search_from] = 1;
      while (1) begin
         any = 0;
         best_f = 0;
         pick = 0;
         for (int i = 0; i < NODES; i++) begin
            if (open_set[i]) begin
               f = longint'(g[i])
                 + ((node_x[i] > node_x[search_to]) ? node_x[i] - node_x[search_to]
                                                    : node_x[search_to] - node_x[i])
                 + ((node_y[i] > node_y[search_to]) ? node_y[i] - node_y[search_to]
                                                    : node_y[search_to] - node_y[i]);
               if (!any || f < best_f) begin
                  any = 1;
                  best_f = f;
                  pick = i;
               end
            end
         end
         if (!any) begin
            // Goal unreachable: one miss word.
            w = '0;
            w.last = 1'b1;
            expect_word(w);
            misses_seen++;
            return;
         end
         if (pick == search_to) break;
         open_set[pick] = 0;
         done_set[pick] = 1;
         for (int k = 0; k < edge_count[pick]; k++) begin
            nb = int'(edge_list[pick][k]);
            if (!done_set[nb]) begin
               ng = longint'(g[pick]) + node_cost[nb];
               if (ng > COST_MAX) ng = COST_MAX;
               if (ng < g[nb]) begin
                  g[nb] = ng[21:0];
                  via[nb] = pick[5:0];
                  open_set[nb] = 1;
               end
            end
         end
      end
      // Walk back from the goal, then emit start first.
      cur = int'(search_to);
      while (route.size() < NODES) begin
         route.push_front(cur[5:0]);
         if (cur == search_from) break;
         cur = int'(via[cur]);
      end
      foreach (route[i]) begin
         w.path_node = route[i];
         w.path_cost = g[search_to];
         w.found     = 1'b1;
         w.last      = (i == route.size() - 1);
         expect_word(w);
      end
   endfunction

   // Fold an accepted request word into the graph copy.
   function automatic void absorb_word(req_word_type w);
      case (w.kind)
         KIND_LOAD: begin
            node_x[w.node_id] = w.x_coord;
            node_y[w.node_id] = w.y_coord;
            node_cost[w.node_id] = w.entry_cost;
         end
         KIND_EDGE: begin
            // Drop edges once the source list is full.
            if (edge_count[w.node_id] < DEGREE_MAX) begin
               edge_list[w.node_id][edge_count[w.node_id]] = w.neighbor_id;
               edge_count[w.node_id]++;
            end
         end
         KIND_SEARCH: begin
            searches_run++;
            plan_path();
         end
         default: ;
      endcase
   endfunction

   // Hold a word on the request port until the block takes it. Entered and
   // left right after a rising edge; start stays high for a following word.
   task automatic send_word(req_word_type w);
      start <= 1'b1;
      req_word <= w;
      do @(posedge clock); while (busy);
      words_sent++;
      absorb_word(w);
   endtask

   task automatic pause(int cycles);
      if (cycles > 0) begin
         start <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   // Bursty sender: mostly back to back, sometimes a random gap.
   task automatic send_bursty(req_word_type w);
      send_word(w);
      if ($urandom_range(0, 5) == 0) pause($urandom_range(1, 6));
   endtask

   // Drop start, wait out every due word, then let the block settle.
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (path_words_due.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_endpoints(logic [5:0] from_node, logic [5:0] to_node);
      csr_we <= 1'b1;
      csr_index <= CSR_START;
      csr_wdata <= from_node;
      @(posedge clock);
      csr_index <= CSR_GOAL;
      csr_wdata <= to_node;
      @(posedge clock);
      csr_we <= 1'b0;
      search_from = from_node;
      search_to = to_node;
   endtask

   function automatic req_word_type make_load(int id, int x, int y, int cost);
      req_word_type w;
      w = '0;
      w.kind = KIND_LOAD;
      w.node_id = 6'(id);
      w.x_coord = 8'(x);
      w.y_coord = 8'(y);
      w.entry_cost = 16'(cost);
      w.neighbor_id = 6'($urandom);
      return w;
   endfunction

   function automatic req_word_type make_edge(int from_node, int to_node);
      req_word_type w;
      w = '0;
      w.kind = KIND_EDGE;
      w.node_id = 6'(from_node);
      w.neighbor_id = 6'(to_node);
      w.x_coord = 8'($urandom);
      w.y_coord = 8'($urandom);
      w.entry_cost = 16'($urandom);
      return w;
   endfunction

   function automatic req_word_type make_search();
      req_word_type w;
      w = REQ_BITS'({$urandom, $urandom});
      w.kind = KIND_SEARCH;
      return w;
   endfunction

   // Field extremes, an unused kind, a full edge list, a tie and a cycle.
   task automatic test_directed();
      req_word_type w;
      send_word(make_load(0, 0, 0, 0));
      send_word(make_load(63, 255, 255, 16'hFFFF));
      send_word(make_load(1, 1, 0, 5));
      send_word(make_load(2, 0, 1, 5));
      send_word(make_load(3, 1, 1, 1));
      w = make_search();
      w.kind = 2'd3;
      send_word(w);
      // Node 0 is sent an edge beyond a full list; that last edge is dropped.
      send_word(make_edge(0, 1));
      send_word(make_edge(0, 2));
      send_word(make_edge(0, 0));
      send_word(make_edge(0, 63));
      send_word(make_edge(0, 3));
      send_word(make_edge(1, 3));
      send_word(make_edge(2, 3));
      send_word(make_edge(3, 0));
      // Start equals goal.
      send_word(make_search());
      drain();
      // Tie between nodes 1 and 2 on the way to 3.
      write_endpoints(6'd0, 6'd3);
      send_word(make_search());
      drain();
      // Unreachable goal.
      write_endpoints(6'd63, 6'd0);
      send_word(make_search());
      drain();
      write_endpoints(6'd0, 6'd63);
      send_word(make_search());
      drain();
   endtask

   // Random grid graph with nearby edges, then searches mixed with reloads.
   task automatic test_random_graph();
      int from_node;
      for (int i = 4; i < NODES - 1; i++)
         send_bursty(make_load(i, $urandom_range(0, 255), $urandom_range(0, 255),
                               ($urandom_range(0, 7) == 0) ? $urandom
                                                          : $urandom_range(0, 300)));
      for (int i = 0; i < 90; i++) begin
         from_node = $urandom_range(0, NODES - 1);
         send_bursty(make_edge(from_node,
                               (from_node + $urandom_range(1, 9)) % NODES));
      end
      for (int n = 0; n < 28; n++) begin
         drain();
         write_endpoints(6'($urandom), 6'($urandom));
         send_bursty(make_search());
         if ($urandom_range(0, 2) == 0)
            send_bursty(make_load($urandom, $urandom, $urandom, $urandom));
         if ($urandom_range(0, 3) == 0)
            send_bursty(make_edge($urandom, $urandom));
      end
      drain();
      // Extreme endpoints last.
      write_endpoints(6'd63, 6'd63);
      send_word(make_search());
      drain();
   endtask

   // Results are strobes: check each against the oldest due word.
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         words_seen++;
         if (path_words_due.size() == 0) begin
            $error("unexpected result word: %p", rsp_word);
            fail_count++;
         end else begin
            if (rsp_word.path_node !== path_words_due[0].path_node) begin
               $error("path_node: expected %0d, got %0d",
                      path_words_due[0].path_node, rsp_word.path_node);
               fail_count++;
            end
            if (rsp_word.path_cost !== path_words_due[0].path_cost) begin
               $error("path_cost: expected %0d, got %0d",
                      path_words_due[0].path_cost, rsp_word.path_cost);
               fail_count++;
            end
            if (rsp_word.found !== path_words_due[0].found) begin
               $error("found: expected %0d, got %0d",
                      path_words_due[0].found, rsp_word.found);
               fail_count++;
            end
            if (rsp_word.last !== path_words_due[0].last) begin
               $error("last: expected %0d, got %0d",
                      path_words_due[0].last, rsp_word.last);
               fail_count++;
            end
            void'(path_words_due.pop_front());
         end
      end
   end

   // Watchdog: end the run when nothing moves for too long.
   always @(posedge clock) begin
      if (reset || rsp_valid || (start && !busy)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("timeout after %0d idle cycles", idle_cycles);
         $display("RESULT: ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      for (int i = 0; i < NODES; i++) begin
         node_x[i] = '0;
         node_y[i] = '0;
         node_cost[i] = '0;
         edge_count[i] = 0;
      end
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random_graph();
      drain();
      $display("sent %0d words, ran %0d searches (%0d misses), checked %0d result words",
               words_sent, searches_run, misses_seen, words_seen);
      if (fail_count == 0 && path_words_due.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
